/* rtl/rpn_tce_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_tce_pkg
// Shared types, codes and column helpers for the postfix truth-column
// evaluator.
// ----------------------------------------------------------------------------
package rpn_tce_pkg;

  // Sizes
  localparam int STACK_DEPTH = 16;
  localparam int MAX_VARS    = 6;
  localparam int COL_W       = 64;
  localparam int NV_W        = 3;
  localparam int OP_W        = 4;
  localparam int ROWS_W      = 7;
  localparam int ERR_W       = 2;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_VAR     = 4'd0;
  localparam logic [OP_W-1:0] OP_NOT     = 4'd1;
  localparam logic [OP_W-1:0] OP_AND     = 4'd2;
  localparam logic [OP_W-1:0] OP_OR      = 4'd3;
  localparam logic [OP_W-1:0] OP_XOR     = 4'd4;
  localparam logic [OP_W-1:0] OP_IMPLIES = 4'd5;
  localparam logic [OP_W-1:0] OP_IFF     = 4'd6;
  localparam logic [OP_W-1:0] OP_FALSE   = 4'd7;
  localparam logic [OP_W-1:0] OP_TRUE    = 4'd8;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [NV_W-1:0] var_index;
    logic            last;
  } token_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROWS_W-1:0] rows;
    logic [ERR_W-1:0]  err;
  } result_t;

  // Number of valid rows for n variables
  function automatic logic [ROWS_W-1:0] row_count(input logic [NV_W-1:0] n);
    return ROWS_W'(1) << n;
  endfunction

  // Ones on the valid rows
  function automatic logic [COL_W-1:0] row_mask(input logic [NV_W-1:0] n);
    logic [COL_W-1:0]  m;
    logic [ROWS_W-1:0] rc;
    rc = row_count(n);
    for (int r = 0; r < COL_W; r++) begin
      m[r] = (ROWS_W'(r) < rc);
    end
    return m;
  endfunction

  // Column of variable k: bit r is bit (n-1-k) of the row number
  function automatic logic [COL_W-1:0] var_col(input logic [NV_W-1:0] n,
                                               input logic [NV_W-1:0] k);
    logic [COL_W-1:0]    col;
    logic [NV_W-1:0]     sh;
    logic [MAX_VARS-1:0] rv;
    col = '0;
    sh  = n - k - NV_W'(1);
    if (k < n) begin
      for (int r = 0; r < COL_W; r++) begin
        rv     = MAX_VARS'(r);
        col[r] = rv[sh];
      end
    end
    return col;
  endfunction

endpackage

/* rtl/rpn_tce_token_reg.sv */
// ----------------------------------------------------------------------------
// rpn_tce_token_reg
// Input register: captures one token item and holds it until the execute
// stage takes it.
// ----------------------------------------------------------------------------
module rpn_tce_token_reg
  import rpn_tce_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_operation,
  input  logic [NV_W-1:0] in_var_index,
  input  logic            in_last_token,
  input  logic            adv,
  output logic            tok_valid,
  output token_t          tok
);

  logic   tok_valid_r;
  logic   tok_valid_nxt;
  token_t tok_r;
  logic   accept;

  // Stall only while a held token cannot move on
  assign in_stall = tok_valid_r & ~adv;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    tok_valid_nxt = tok_valid_r;
    if (accept) begin
      tok_valid_nxt = 1'b1;
    end else if (adv) begin
      tok_valid_nxt = 1'b0;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r <= '{op: in_operation, var_index: in_var_index, last: in_last_token};
    end
  end

  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

endmodule

/* rtl/rpn_tce_stack.sv */
// ----------------------------------------------------------------------------
// rpn_tce_stack
// Execute stage: applies one token to the column stack per cycle, a last token
// waiting for a free result slot, and forms the result item on the last token.
// ----------------------------------------------------------------------------
module rpn_tce_stack
  import rpn_tce_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  token_t          tok,
  input  logic [NV_W-1:0] eff_vars,
  input  logic            slot_free,
  output logic            adv,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [1:0] {K_NONE, K_PUSH, K_UNARY, K_BINARY} kind_t;

  // Entry 0 is the top; entries shift on push and pop
  logic [COL_W-1:0]   stk_r   [STACK_DEPTH];
  logic [COL_W-1:0]   stk_nxt [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [ERR_W-1:0]   err_r;
  logic [ERR_W-1:0]   err_nxt;
  logic [ERR_W-1:0]   op_err;
  logic [ERR_W-1:0]   fin_err;
  logic [COL_W-1:0]   mask;
  logic [COL_W-1:0]   opa;
  logic [COL_W-1:0]   opb;
  logic [COL_W-1:0]   val;
  logic [COL_W-1:0]   top;
  kind_t              kind;

  assign adv       = tok_valid & (~tok.last | slot_free);
  assign res_valid = adv & tok.last;
  assign mask      = row_mask(eff_vars);

  // Operands; missing ones read as zero
  assign opa = (depth_r != '0) ? stk_r[0] : '0;
  assign opb = (depth_r > DEPTH_W'(1)) ? stk_r[1] : '0;

  // Decode the token
  always_comb begin
    kind = K_NONE;
    val  = '0;
    case (tok.op)
      OP_VAR:     begin kind = K_PUSH;   val = var_col(eff_vars, tok.var_index); end
      OP_FALSE:   begin kind = K_PUSH;   val = '0;                               end
      OP_TRUE:    begin kind = K_PUSH;   val = '1;                               end
      OP_NOT:     begin kind = K_UNARY;  val = ~opa;                             end
      OP_AND:     begin kind = K_BINARY; val = opa & opb;                        end
      OP_OR:      begin kind = K_BINARY; val = opa | opb;                        end
      OP_XOR:     begin kind = K_BINARY; val = opa ^ opb;                        end
      OP_IMPLIES: begin kind = K_BINARY; val = ~opb | opa;                       end
      OP_IFF:     begin kind = K_BINARY; val = ~(opa ^ opb);                     end
      default:    begin kind = K_NONE;   val = '0;                               end
    endcase
  end

  // Next stack contents, depth and error
  always_comb begin
    stk_nxt   = stk_r;
    depth_nxt = depth_r;
    op_err    = ERR_NONE;
    case (kind)
      K_PUSH: begin
        if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
          op_err = ERR_OVER;
        end else begin
          for (int i = 1; i < STACK_DEPTH; i++) begin
            stk_nxt[i] = stk_r[i-1];
          end
          stk_nxt[0] = val & mask;
          depth_nxt  = depth_r + DEPTH_W'(1);
        end
      end
      K_UNARY: begin
        if (depth_r == '0) begin
          op_err    = ERR_UNDER;
          depth_nxt = DEPTH_W'(1);
        end
        stk_nxt[0] = val & mask;
      end
      K_BINARY: begin
        if (depth_r < DEPTH_W'(2)) begin
          op_err = ERR_UNDER;
        end
        depth_nxt = (depth_r < DEPTH_W'(2)) ? DEPTH_W'(1) : depth_r - DEPTH_W'(1);
        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
          stk_nxt[i] = stk_r[i+1];
        end
        stk_nxt[0] = val & mask;
      end
      default: begin
        op_err = ERR_NONE;
      end
    endcase
    // First error wins
    err_nxt = (err_r != ERR_NONE) ? err_r : op_err;
    // An empty stack at the end counts as underflow
    fin_err = ((depth_nxt == '0) && (err_nxt == ERR_NONE)) ? ERR_UNDER : err_nxt;
    top     = (depth_nxt != '0) ? stk_nxt[0] : '0;
  end

  assign res = '{column: top & mask, rows: row_count(eff_vars), err: fin_err};

  // Advance control state; clear for the next formula after the last token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ERR_NONE;
    end else if (adv) begin
      if (tok.last) begin
        depth_r <= '0;
        err_r   <= ERR_NONE;
      end else begin
        depth_r <= depth_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // Update stack entries
  always_ff @(posedge clk) begin
    if (adv) begin
      stk_r <= stk_nxt;
    end
  end

endmodule

/* rtl/rpn_tce_result_reg.sv */
// ----------------------------------------------------------------------------
// rpn_tce_result_reg
// Output register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module rpn_tce_result_reg
  import rpn_tce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  result_t           res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_truth_column,
  output logic [ROWS_W-1:0] out_row_count,
  output logic [ERR_W-1:0]  out_error_code
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t res_r;

  assign slot_free = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a new item only when the slot frees
  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_truth_column = res_r.column;
  assign out_row_count    = res_r.rows;
  assign out_error_code   = res_r.err;

endmodule

/* rtl/rpn_truth_column_evaluator_top.sv */
// ----------------------------------------------------------------------------
// rpn_truth_column_evaluator_top
// Postfix propositional formula evaluator over 64-row truth-table columns.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in_     | input     | in_valid / in_stall   | operation, var_index, last_token
//   out_    | output    | out_valid / out_stall | truth_column, row_count, error_code
//   cfg_    | input     | cfg_wr_en             | cfg_wr_data (num_vars)
//
// One token item per cycle while no stalled result holds back a last token;
// the result item is registered when the execute stage takes its last token.
// The figure is set by the execute stage, which reads and rewrites top entries.
// Reset clears valid flags, stack depth, error and num_vars; stack entries
// are not cleared. A stalled result holds the output register; a last token
// then waits in the input register and in_stall rises.
// ----------------------------------------------------------------------------
module rpn_truth_column_evaluator_top
  import rpn_tce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NV_W-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [NV_W-1:0]   in_var_index,
  input  logic              in_last_token,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_truth_column,
  output logic [ROWS_W-1:0] out_row_count,
  output logic [ERR_W-1:0]  out_error_code
);

  logic [NV_W-1:0] num_vars_r;
  logic [NV_W-1:0] eff_vars;
  logic            adv;
  logic            tok_valid;
  token_t          tok;
  logic            slot_free;
  logic            res_valid;
  result_t         res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= '0;
    end else if (cfg_wr_en) begin
      num_vars_r <= cfg_wr_data;
    end
  end

  // Saturate variable count
  assign eff_vars = (num_vars_r > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : num_vars_r;

  rpn_tce_token_reg u_token_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_var_index  (in_var_index),
    .in_last_token (in_last_token),
    .adv           (adv),
    .tok_valid     (tok_valid),
    .tok           (tok)
  );

  rpn_tce_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .eff_vars  (eff_vars),
    .slot_free (slot_free),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  rpn_tce_result_reg u_result_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_truth_column (out_truth_column),
    .out_row_count    (out_row_count),
    .out_error_code   (out_error_code)
  );

endmodule

/* rtl/rpn_tce_checker.sv */
// ----------------------------------------------------------------------------
// rpn_tce_checker
// Port-level checks on the result channel of the evaluator.
// ----------------------------------------------------------------------------
module rpn_tce_checker
  import rpn_tce_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COL_W-1:0]  out_truth_column,
  input logic [ROWS_W-1:0] out_row_count,
  input logic [ERR_W-1:0]  out_error_code
);

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_truth_column)
      && $stable(out_row_count) && $stable(out_error_code))
    else $error("stalled result item changed");

  // Row count is a power of two
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_row_count))
    else $error("row count not a power of two");

  // No bits above the valid rows
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_count != ROWS_W'(COL_W))
      |-> ((out_truth_column >> out_row_count) == '0))
    else $error("column bits set beyond valid rows");

  // Only defined error codes
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_NONE) || (out_error_code == ERR_UNDER)
      || (out_error_code == ERR_OVER))
    else $error("undefined error code");

endmodule

bind rpn_truth_column_evaluator_top rpn_tce_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_truth_column (out_truth_column),
  .out_row_count    (out_row_count),
  .out_error_code   (out_error_code)
);

/* sim/rpn_truth_column_evaluator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_truth_column_evaluator_top_tb
// Self-checking bench for the postfix truth-column evaluator. Tokens are
// pushed through the valid/stall input with random gaps while the result side
// stalls at random. A scoreboard keeps its own column stack, predicts the
// column, row count and error code of every formula, and compares each
// result item field by field. The run covers all row counts, malformed
// formulas, stack overflow, reserved codes and a long output hold-off.
// ----------------------------------------------------------------------------
module rpn_truth_column_evaluator_top_tb;
  import rpn_tce_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int PHASE_TOKENS   = 45;
  localparam int IDLE_PCT       = 32;

  // Codes the block does not define; they must leave the stack alone
  localparam logic [OP_W-1:0] OP_RSVD_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 4'd15;

  // --------------------------------------------------------------------------
  // Scoreboard: own column stack, expected results in arrival order
  // --------------------------------------------------------------------------
  class formula_checker;
    logic [COL_W-1:0] columns [STACK_DEPTH];
    int               depth;
    logic [ERR_W-1:0] sticky_err;
    logic [NV_W-1:0]  num_vars;
    result_t          pending_results [$];
    int               fails;
    int               tokens_seen;
    int               results_checked;
    int               under_count;
    int               over_count;

    function new();
      depth           = 0;
      sticky_err      = ERR_NONE;
      num_vars        = '0;
      fails           = 0;
      tokens_seen     = 0;
      results_checked = 0;
      under_count     = 0;
      over_count      = 0;
    endfunction

    task report(string msg);
      $display("  mismatch @%0t: %s", $time, msg);
      fails++;
    endtask

    function void set_vars(logic [NV_W-1:0] v);
      num_vars = v;
    endfunction

    // Saturate to the widest supported table
    function int used_vars();
      return (num_vars > MAX_VARS) ? MAX_VARS : int'(num_vars);
    endfunction

    function logic [COL_W-1:0] rows_mask();
      if (used_vars() >= 6) return '1;
      return (64'd1 << (1 << used_vars())) - 64'd1;
    endfunction

    function logic [COL_W-1:0] var_column(logic [NV_W-1:0] k);
      logic [COL_W-1:0] col;
      int               n;
      n   = used_vars();
      col = '0;
      if (int'(k) >= n) return col;
      for (int r = 0; r < (1 << n); r++) begin
        col[r] = 1'((r >> (n - 1 - int'(k))) & 1);
      end
      return col;
    endfunction

    function void flag_error(logic [ERR_W-1:0] code);
      if (sticky_err == ERR_NONE) sticky_err = code;
    endfunction

    // Drop pushes onto a full stack
    function void push_column(logic [COL_W-1:0] v);
      if (depth >= STACK_DEPTH) begin
        flag_error(ERR_OVER);
        return;
      end
      columns[depth] = v & rows_mask();
      depth++;
    endfunction

    // Missing operands read as zeros
    function logic [COL_W-1:0] pop_column();
      if (depth == 0) begin
        flag_error(ERR_UNDER);
        return '0;
      end
      depth--;
      return columns[depth];
    endfunction

    function void take_token(token_t t);
      logic [COL_W-1:0] a;
      logic [COL_W-1:0] b;
      result_t          res;
      tokens_seen++;
      case (t.op)
        OP_VAR:     push_column(var_column(t.var_index));
        OP_NOT:     begin a = pop_column(); push_column(~a); end
        OP_AND:     begin a = pop_column(); b = pop_column(); push_column(a & b); end
        OP_OR:      begin a = pop_column(); b = pop_column(); push_column(a | b); end
        OP_XOR:     begin a = pop_column(); b = pop_column(); push_column(a ^ b); end
        OP_IMPLIES: begin a = pop_column(); b = pop_column(); push_column(~b | a); end
        OP_IFF:     begin a = pop_column(); b = pop_column(); push_column(~(a ^ b)); end
        OP_FALSE:   push_column('0);
        OP_TRUE:    push_column('1);
        default:    ;
      endcase
      if (!t.last) return;
      // Emit the top column and clear for the next formula
      if (depth == 0) begin
        flag_error(ERR_UNDER);
        res.column = '0;
      end else begin
        res.column = columns[depth-1] & rows_mask();
      end
      res.rows = ROWS_W'(1) << used_vars();
      res.err  = sticky_err;
      if (sticky_err == ERR_UNDER) under_count++;
      if (sticky_err == ERR_OVER) over_count++;
      pending_results.push_back(res);
      depth      = 0;
      sticky_err = ERR_NONE;
    endfunction

    task check_result(logic [COL_W-1:0] col, logic [ROWS_W-1:0] rows,
                      logic [ERR_W-1:0] err);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result column=%h rows=%0d err=%0d", col, rows, err));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (col !== want.column)
        report($sformatf("column %h, want %h", col, want.column));
      if (rows !== want.rows)
        report($sformatf("row_count %0d, want %0d", rows, want.rows));
      if (err !== want.err)
        report($sformatf("error_code %0d, want %0d", err, want.err));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_wr_en     = 1'b0;
  logic [NV_W-1:0]   cfg_wr_data   = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation  = '0;
  logic [NV_W-1:0]   in_var_index  = '0;
  logic              in_last_token = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [COL_W-1:0]  out_truth_column;
  logic [ROWS_W-1:0] out_row_count;
  logic [ERR_W-1:0]  out_error_code;

  formula_checker checker_h;
  token_t         formula_q [$];
  bit             quiet_mode    = 1'b0;
  int             holdoff_asked = 0;
  int             holdoff_taken = 0;
  int             cycle_count   = 0;
  int             settings_used = 0;

  rpn_truth_column_evaluator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_var_index     (in_var_index),
    .in_last_token    (in_last_token),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_truth_column (out_truth_column),
    .out_row_count    (out_row_count),
    .out_error_code   (out_error_code)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, checker_h.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Observe both handshakes on the edge that completes them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        checker_h.take_token('{op: in_operation, var_index: in_var_index,
                               last: in_last_token});
      if (out_valid && !out_stall)
        checker_h.check_result(out_truth_column, out_row_count, out_error_code);
    end
  end

  // Result side: random stall, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holdoff_taken != holdoff_asked) begin
        holdoff_taken++;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic token_t tok(logic [OP_W-1:0] op, int k, bit last);
    token_t t;
    t.op        = op;
    t.var_index = NV_W'(k);
    t.last      = last;
    return t;
  endfunction

  // Random operand: mostly in-range variables, some out of range, some constants
  function automatic token_t leaf();
    case ($urandom_range(0, 9))
      0:       return tok(OP_FALSE, $urandom_range(0, 7), 1'b0);
      1:       return tok(OP_TRUE, $urandom_range(0, 7), 1'b0);
      2:       return tok(OP_VAR, $urandom_range(6, 7), 1'b0);
      default: return tok(OP_VAR, $urandom_range(0, 5), 1'b0);
    endcase
  endfunction

  function automatic token_t binary_op();
    return tok(OP_W'($urandom_range(OP_AND, OP_IFF)), $urandom_range(0, 7), 1'b0);
  endfunction

  // Fill formula_q with one formula, mostly well formed
  function automatic void make_formula();
    int kind;
    int leaves_left;
    int d;
    formula_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      leaves_left = $urandom_range(1, 8);
      d = 0;
      while (leaves_left > 0 || d > 1) begin
        if (leaves_left > 0 && (d < 2 || $urandom_range(0, 1) == 1)) begin
          formula_q.push_back(leaf());
          d++;
          leaves_left--;
        end else if ($urandom_range(0, 3) != 0) begin
          formula_q.push_back(binary_op());
          d--;
        end else begin
          formula_q.push_back(tok(OP_NOT, $urandom_range(0, 7), 1'b0));
        end
        if ($urandom_range(0, 11) == 0)
          formula_q.push_back(tok(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                                  $urandom_range(0, 7), 1'b0));
      end
      if ($urandom_range(0, 3) == 0)
        formula_q.push_back(tok(OP_NOT, $urandom_range(0, 7), 1'b0));
    end else if (kind < 86) begin
      // Around the full-stack boundary
      repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 3)) formula_q.push_back(leaf());
      repeat ($urandom_range(0, 3)) formula_q.push_back(binary_op());
    end else if (kind < 94) begin
      // Mostly leftover operands at the end
      repeat ($urandom_range(2, 4)) formula_q.push_back(leaf());
      if ($urandom_range(0, 1) == 1) formula_q.push_back(binary_op());
    end else begin
      repeat ($urandom_range(1, 6))
        formula_q.push_back(tok(OP_W'($urandom_range(0, 15)), $urandom_range(0, 7), 1'b0));
    end
    formula_q[formula_q.size()-1].last = 1'b1;
  endfunction

  // Offer one item and hold it until taken
  task automatic send_token(token_t t);
    while (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= t.op;
    in_var_index  <= t.var_index;
    in_last_token <= t.last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_formula();
    foreach (formula_q[i]) send_token(formula_q[i]);
  endtask

  // Stop offering and wait for every result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_num_vars(logic [NV_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    checker_h.set_vars(v);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int nv_plan [9];
    int phase_tokens;
    nv_plan = '{0, 6, 1, 7, 2, 5, 3, 4, 6};
    checker_h = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_num_vars(3'd3);

    // Directed: every operator, both constants, edge var indexes, error cases
    formula_q = '{tok(OP_VAR, 0, 0), tok(OP_VAR, 1, 0), tok(OP_AND, 0, 1),
                  tok(OP_VAR, 2, 0), tok(OP_NOT, 0, 0), tok(OP_VAR, 0, 0), tok(OP_OR, 0, 1),
                  tok(OP_TRUE, 0, 0), tok(OP_FALSE, 0, 0), tok(OP_XOR, 0, 1),
                  tok(OP_VAR, 1, 0), tok(OP_VAR, 2, 0), tok(OP_IMPLIES, 0, 1),
                  tok(OP_VAR, 0, 0), tok(OP_VAR, 0, 0), tok(OP_IFF, 7, 1),
                  tok(OP_VAR, 5, 0), tok(OP_VAR, 7, 1),
                  tok(OP_AND, 0, 1),
                  tok(OP_RSVD_LO, 0, 1),
                  tok(OP_VAR, 2, 0), tok(OP_RSVD_HI, 7, 1)};
    send_formula();
    drain();

    // Random phases, one register setting each
    foreach (nv_plan[p]) begin
      write_num_vars(NV_W'(nv_plan[p]));
      if (p == 2) holdoff_asked++;
      quiet_mode   = (p == 4);
      phase_tokens = 0;
      while (phase_tokens < PHASE_TOKENS) begin
        make_formula();
        phase_tokens += formula_q.size();
        send_formula();
        if ($urandom_range(0, 19) == 0) drain();
      end
      quiet_mode = 1'b0;
      drain();
    end

    $display("covered %0d tokens, %0d formulas checked over %0d num_vars settings",
             checker_h.tokens_seen, checker_h.results_checked, settings_used);
    $display("formulas ending in underflow: %0d, in overflow: %0d; %0d cycles",
             checker_h.under_count, checker_h.over_count, cycle_count);
    if (checker_h.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
